@@ sv/physical_frame_bitmap_allocator_macros.svh @@
// assertion helpers for the frame allocator
`ifndef PHYSICAL_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PHYSICAL_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/pfba_pkg.sv @@
package pfba_pkg;

	localparam int NUM_FRAMES = 4096;
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = NUM_FRAMES / WORD_BITS;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int BIT_AW     = $clog2(WORD_BITS);
	localparam int FRAME_W    = 12;
	localparam int CFG_W      = 13;
	localparam int LIMIT_W    = WORD_AW + 1;
	localparam int SCAN_LANES = 16;
	localparam int SCAN_STEPS = NUM_WORDS / SCAN_LANES;
	localparam int STEP_W     = $clog2(SCAN_STEPS);
	localparam int LANE_W     = $clog2(SCAN_LANES);
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4096);

	// register index decoded from paddr
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_MARK  = 2'd2,
		ACT_TEST  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_MAPPED    = 2'd1,
		STAT_NO_FREE   = 2'd2,
		STAT_FREE_ZERO = 2'd3
	} status_t;

	typedef struct packed {
		action_t              action;
		logic [FRAME_W-1:0]   frame_index;
		logic                 is_kernel;
		logic                 is_writeable;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]   frame_out;
		logic                 present;
		logic                 writable;
		logic                 user;
		logic                 frame_was_set;
		status_t              status;
	} rsp_t;

	// sequencer to word scanner
	typedef struct packed {
		logic                 go;
		logic [LIMIT_W-1:0]   limit;
		logic                 upd_en;
		logic [WORD_AW-1:0]   upd_word;
		logic                 upd_full;
	} scan_ctl_t;

	// word scanner back to sequencer
	typedef struct packed {
		logic                 done;
		logic                 found;
		logic [WORD_AW-1:0]   word;
	} scan_sts_t;

endpackage

@@ sv/pfba_ram.sv @@
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/pfba_scan.sv @@
module pfba_scan import pfba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_ctl_t ctl,
	output scan_sts_t sts
);

	typedef enum logic {
		SC_IDLE,
		SC_RUN
	} sc_state_t;

	sc_state_t           state_q;
	logic [STEP_W-1:0]   step_q;
	scan_sts_t           sts_q;
	logic [NUM_WORDS-1:0] full_q;
	logic [SCAN_LANES-1:0] open_lanes;
	logic                hit;
	logic [LANE_W-1:0]   hit_lane;

	// per-word full summary, all clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (ctl.upd_en) begin
			full_q[ctl.upd_word] <= ctl.upd_full;
		end
	end

	// words of the current group that still have a free frame and lie below the limit
	always_comb begin
		logic [WORD_AW-1:0] w;
		w = '0;
		for (int l = 0; l < SCAN_LANES; l++) begin
			w = {step_q, LANE_W'(l)};
			open_lanes[l] = !full_q[w] && ({1'b0, w} < ctl.limit);
		end
	end

	// lowest open word in the group
	always_comb begin
		hit      = 1'b0;
		hit_lane = '0;
		for (int l = SCAN_LANES - 1; l >= 0; l--) begin
			if (open_lanes[l]) begin
				hit      = 1'b1;
				hit_lane = LANE_W'(l);
			end
		end
	end

	// group stepper
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			step_q  <= '0;
			sts_q   <= '0;
		end else begin
			sts_q.done <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (ctl.go) begin
						step_q  <= '0;
						state_q <= SC_RUN;
					end
				end
				SC_RUN: begin
					if (hit) begin
						sts_q.done  <= 1'b1;
						sts_q.found <= 1'b1;
						sts_q.word  <= {step_q, hit_lane};
						state_q     <= SC_IDLE;
					end else if (step_q == STEP_W'(SCAN_STEPS - 1)) begin
						sts_q.done  <= 1'b1;
						sts_q.found <= 1'b0;
						sts_q.word  <= '0;
						state_q     <= SC_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign sts = sts_q;

endmodule

@@ sv/physical_frame_bitmap_allocator.sv @@
// channel   direction  handshake                  payload
// request   in         start high, busy low       req   (req_t)
// result    out        done, one-cycle strobe     rsp   (rsp_t)
// config    in/out     apb write, pready fixed 1  pwdata[12:0] at paddr 0
//
// one result per request; the result strobe comes in the cycle after acceptance for an
// already-mapped alloc or a free of frame zero; free, mark and test go through the read
// and modify states (word read, then write back except for test), and a searching alloc
// scans first: the word scanner checks 16 word-full flags per cycle over up to 8 groups
// busy stays high until the result shows; the receiver cannot stall
// reset clears the bitmap at once through per-word valid flags, no clearing pass
`include "physical_frame_bitmap_allocator_macros.svh"

module physical_frame_bitmap_allocator import pfba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_MOD
	} state_t;

	state_t               state_q;
	req_t                 item_q;
	logic [WORD_AW-1:0]   word_q;
	logic                 done_q;
	rsp_t                 rsp_q;
	logic [CFG_W-1:0]     frames_q;
	logic [NUM_WORDS-1:0] valid_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [CFG_W-1:0]     frames_clamped;
	logic [LIMIT_W-1:0]   words_limit;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] bit_mask;
	logic [BIT_AW-1:0]    free_bit;
	logic [BIT_AW-1:0]    bit_sel;
	logic                 ram_we;
	scan_ctl_t            scan_ctl;
	scan_sts_t            scan_sts;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// config register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_wr && paddr[APB_AW-1:2] == REG_FRAMES_IN_USE) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[APB_AW-1:2] == REG_FRAMES_IN_USE) ? APB_DW'(frames_q) : '0;

	// number of whole words searched
	assign frames_clamped = (frames_q > CFG_W'(NUM_FRAMES)) ? CFG_W'(NUM_FRAMES) : frames_q;
	assign words_limit    = LIMIT_W'(frames_clamped >> BIT_AW);

	// bitmap storage
	pfba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(word_q),
		.wdata(new_word),
		.raddr(word_q),
		.rdata(ram_rdata)
	);

	// words never written read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[word_q] <= 1'b1;
		end
	end

	assign rd_word = valid_q[word_q] ? ram_rdata : '0;

	// lowest clear bit of the fetched word
	always_comb begin
		free_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!rd_word[b]) begin
				free_bit = BIT_AW'(b);
			end
		end
	end

	// read-modify-write of one word
	assign bit_sel  = (item_q.action == ACT_ALLOC) ? free_bit
	                                               : item_q.frame_index[BIT_AW-1:0];
	assign bit_mask = WORD_BITS'(1) << bit_sel;

	always_comb begin
		case (item_q.action)
			ACT_ALLOC: new_word = rd_word | bit_mask;
			ACT_MARK:  new_word = rd_word | bit_mask;
			ACT_FREE:  new_word = rd_word & ~bit_mask;
			default:   new_word = rd_word;
		endcase
	end

	assign ram_we = (state_q == ST_MOD) && (item_q.action != ACT_TEST);

	// word scanner control
	assign scan_ctl.go       = accept && req.action == ACT_ALLOC && req.frame_index == '0;
	assign scan_ctl.limit    = words_limit;
	assign scan_ctl.upd_en   = ram_we;
	assign scan_ctl.upd_word = word_q;
	assign scan_ctl.upd_full = &new_word;

	pfba_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scan_ctl),
		.sts   (scan_sts)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_q  <= '0;
			word_q  <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= req;
						word_q <= WORD_AW'(req.frame_index >> BIT_AW);
						if (req.action == ACT_ALLOC) begin
							if (req.frame_index != '0) begin
								done_q          <= 1'b1;
								rsp_q           <= '0;
								rsp_q.frame_out <= req.frame_index;
								rsp_q.status    <= STAT_MAPPED;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (req.action == ACT_FREE && req.frame_index == '0) begin
							done_q       <= 1'b1;
							rsp_q        <= '0;
							rsp_q.status <= STAT_FREE_ZERO;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SCAN: begin
					if (scan_sts.done) begin
						if (scan_sts.found) begin
							word_q  <= scan_sts.word;
							state_q <= ST_READ;
						end else begin
							done_q       <= 1'b1;
							rsp_q        <= '0;
							rsp_q.status <= STAT_NO_FREE;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					done_q       <= 1'b1;
					rsp_q        <= '0;
					rsp_q.status <= STAT_OK;
					if (item_q.action == ACT_ALLOC) begin
						rsp_q.frame_out <= FRAME_W'({word_q, free_bit});
						rsp_q.present   <= 1'b1;
						rsp_q.writable  <= item_q.is_writeable;
						rsp_q.user      <= !item_q.is_kernel;
					end
					if (item_q.action == ACT_TEST) begin
						rsp_q.frame_was_set <= rd_word[bit_sel];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`PFBA_ASSERT_NEXT(a_search_goes_busy, clk, arst_n, scan_ctl.go, busy, "no search start")
	`PFBA_ASSERT_SAME(a_scan_done_in_scan, clk, arst_n, scan_sts.done, state_q == ST_SCAN, "stray")
	`PFBA_ASSERT_SAME(a_done_not_busy, clk, arst_n, done, !busy, "result while still busy")
	`PFBA_ASSERT_NEXT(a_written_valid, clk, arst_n, ram_we, valid_q[$past(word_q)], "not valid")

endmodule
